// ===== rtl/suga_pkg.sv =====
// Shared types and constants for the group store with per-group add.
// Used by suga_alu and set_union_with_group_add; no dependencies.
`default_nettype none

package suga_pkg;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned MemberW = 10;
  localparam int unsigned AmountW = 20;
  localparam int unsigned ValueW  = 32;

  typedef enum logic [FuncW-1:0] {
    FUNC_ADD  = 2'd0,
    FUNC_JOIN = 2'd1,
    FUNC_GET  = 2'd2
  } suga_func_e;

  typedef struct packed {
    logic               join_op;
    logic [AmountW-1:0] amount;
  } suga_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/suga_mem.sv =====
// Single-port-write, single-port-read memory holding each member's label and value.
// Read data is registered. Depends on nothing else.
`default_nettype none

module suga_mem #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10,
  parameter int unsigned DataW = 42
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [DataW-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [DataW-1:0] rd_data_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/suga_alu.sv =====
// Shared update unit: compares one entry's label and forms its new label and value.
// Depends on suga_pkg for the control struct and field widths.
`default_nettype none

module suga_alu #(
  parameter int unsigned LabelW = 10
) (
  input  wire suga_pkg::suga_ctrl_t              ctrl_i,
  input  wire logic [LabelW-1:0]                 keep_label_i,
  input  wire logic [LabelW-1:0]                 gone_label_i,
  input  wire logic [LabelW-1:0]                 entry_label_i,
  input  wire logic [suga_pkg::ValueW-1:0]       entry_value_i,
  output logic                                   we_o,
  output logic      [LabelW-1:0]                 label_o,
  output logic      [suga_pkg::ValueW-1:0]       value_o
);

  logic [LabelW-1:0]           match_label;
  logic [suga_pkg::ValueW:0]   sum;

  assign match_label = ctrl_i.join_op ? gone_label_i : keep_label_i;
  assign we_o        = (entry_label_i == match_label);
  assign sum         = {1'b0, entry_value_i} +
                       (suga_pkg::ValueW + 1)'(ctrl_i.amount);

  always_comb begin
    if (ctrl_i.join_op) begin
      label_o = keep_label_i;
      value_o = entry_value_i;
    end else begin
      label_o = entry_label_i;
      value_o = sum[suga_pkg::ValueW] ? {suga_pkg::ValueW{1'b1}}
                                      : sum[suga_pkg::ValueW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/set_union_with_group_add.sv =====
// Top level of the group store: request sequencer, output register and assertions.
// Depends on suga_pkg, suga_mem and suga_alu.
//
// Usage: requests enter on in_valid_i/in_stall_o with func_i, member_i, partner_i
// and amount_i. A request is taken when in_valid_i is high and in_stall_o is low.
// An add sweeps every member entry through one shared update unit. A join
// sweeps them as well, but returns to idle after reading both labels when
// both members already share a group. A get reads the member's entry and then
// presents value_o on out_valid_o; out-of-range members read as zero. Adds and
// joins with an out-of-range member, and the unused func code, are dropped
// without leaving idle. The sweep rate is set by the single read port and
// single write port of the entry memory. After reset a clearing pass writes
// every entry with in_stall_o high. A finished get result waits in the output
// register while out_stall_i is high; the block keeps taking requests meanwhile,
// and a second get holds in its get state until the register is free.
`default_nettype none

module set_union_with_group_add #(
  parameter int unsigned NUM_MEMBERS = 1024
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [suga_pkg::FuncW-1:0]          func_i,
  input  wire logic [suga_pkg::MemberW-1:0]        member_i,
  input  wire logic [suga_pkg::MemberW-1:0]        partner_i,
  input  wire logic [suga_pkg::AmountW-1:0]        amount_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic      [suga_pkg::ValueW-1:0]         value_o
);

  localparam int unsigned IdxW  = $clog2(NUM_MEMBERS);
  localparam int unsigned CntW  = IdxW + 1;
  localparam int unsigned DataW = IdxW + suga_pkg::ValueW;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LAB,
    ST_LABB,
    ST_SWEEP,
    ST_GET
  } state_e;

  state_e                        state_q, state_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic                          s_vld_q, s_vld_d;
  logic [IdxW-1:0]               s_addr_q, s_addr_d;
  logic                          join_q, join_d;
  logic [IdxW-1:0]               part_q, part_d;
  logic [IdxW-1:0]               lab_a_q, lab_a_d;
  logic [IdxW-1:0]               lab_b_q, lab_b_d;
  logic [suga_pkg::AmountW-1:0]  amount_q, amount_d;
  logic                          oor_q, oor_d;
  logic                          out_valid_q, out_valid_d;
  logic [suga_pkg::ValueW-1:0]   value_q, value_d;

  logic                          mem_we;
  logic [IdxW-1:0]               mem_wr_addr;
  logic [DataW-1:0]              mem_wr_data;
  logic                          mem_rd_en;
  logic [IdxW-1:0]               mem_rd_addr;
  logic [DataW-1:0]              mem_rd_data;
  logic [IdxW-1:0]               rd_label;
  logic [suga_pkg::ValueW-1:0]   rd_value;

  suga_pkg::suga_ctrl_t          alu_ctrl;
  logic                          alu_we;
  logic [IdxW-1:0]               alu_label;
  logic [suga_pkg::ValueW-1:0]   alu_value;

  logic                          member_ok;
  logic                          partner_ok;

  assign member_ok  = (32'(member_i) < NUM_MEMBERS);
  assign partner_ok = (32'(partner_i) < NUM_MEMBERS);
  assign rd_label   = mem_rd_data[DataW-1:suga_pkg::ValueW];
  assign rd_value   = mem_rd_data[suga_pkg::ValueW-1:0];

  assign alu_ctrl.join_op = join_q;
  assign alu_ctrl.amount  = amount_q;

  suga_mem #(
    .Depth (NUM_MEMBERS),
    .AddrW (IdxW),
    .DataW (DataW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  suga_alu #(
    .LabelW (IdxW)
  ) u_alu (
    .ctrl_i        (alu_ctrl),
    .keep_label_i  (lab_a_q),
    .gone_label_i  (lab_b_q),
    .entry_label_i (rd_label),
    .entry_value_i (rd_value),
    .we_o          (alu_we),
    .label_o       (alu_label),
    .value_o       (alu_value)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    s_vld_d     = 1'b0;
    s_addr_d    = s_addr_q;
    join_d      = join_q;
    part_d      = part_q;
    lab_a_d     = lab_a_q;
    lab_b_d     = lab_b_q;
    amount_d    = amount_q;
    oor_d       = oor_q;
    out_valid_d = out_valid_q & out_stall_i;
    value_d     = value_q;
    mem_we      = 1'b0;
    mem_wr_addr = s_addr_q;
    mem_wr_data = {alu_label, alu_value};
    mem_rd_en   = 1'b0;
    mem_rd_addr = IdxW'(member_i);

    case (state_q)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_wr_addr = cnt_q[IdxW-1:0];
        mem_wr_data = {cnt_q[IdxW-1:0], {suga_pkg::ValueW{1'b0}}};
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == CntW'(NUM_MEMBERS - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          join_d   = 1'b0;
          amount_d = amount_i;
          part_d   = IdxW'(partner_i);
          case (suga_pkg::suga_func_e'(func_i))
            suga_pkg::FUNC_ADD: begin
              if (member_ok) begin
                mem_rd_en = 1'b1;
                state_d   = ST_LAB;
              end
            end
            suga_pkg::FUNC_JOIN: begin
              join_d = 1'b1;
              if (member_ok && partner_ok) begin
                mem_rd_en = 1'b1;
                state_d   = ST_LAB;
              end
            end
            suga_pkg::FUNC_GET: begin
              mem_rd_en = member_ok;
              oor_d     = !member_ok;
              state_d   = ST_GET;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_LAB: begin
        lab_a_d = rd_label;
        if (join_q) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = part_q;
          state_d     = ST_LABB;
        end else begin
          cnt_d   = '0;
          state_d = ST_SWEEP;
        end
      end
      ST_LABB: begin
        lab_b_d = rd_label;
        cnt_d   = '0;
        if (rd_label == lab_a_q) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        mem_we = s_vld_q & alu_we;
        if (cnt_q != CntW'(NUM_MEMBERS)) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = cnt_q[IdxW-1:0];
          s_vld_d     = 1'b1;
          s_addr_d    = cnt_q[IdxW-1:0];
          cnt_d       = cnt_q + 1'b1;
        end else if (!s_vld_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_GET: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          value_d     = oor_q ? '0 : rd_value;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      s_vld_q     <= 1'b0;
      s_addr_q    <= '0;
      join_q      <= 1'b0;
      part_q      <= '0;
      lab_a_q     <= '0;
      lab_b_q     <= '0;
      amount_q    <= '0;
      oor_q       <= 1'b0;
      out_valid_q <= 1'b0;
      value_q     <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      s_vld_q     <= s_vld_d;
      s_addr_q    <= s_addr_d;
      join_q      <= join_d;
      part_q      <= part_d;
      lab_a_q     <= lab_a_d;
      lab_b_q     <= lab_b_d;
      amount_q    <= amount_d;
      oor_q       <= oor_d;
      out_valid_q <= out_valid_d;
      value_q     <= value_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

`ifndef ASSERT_OFF
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mem_we)
    else $error("memory written while idle");

  a_result_from_get: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_GET))
    else $error("result raised outside a get");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(NUM_MEMBERS))
    else $error("sweep counter past member count");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking bench for set_union_with_group_add: adds, joins, gets and the unused func code.
// A group model predicts each get value; results are checked in order under idle and stall.
// Depends on suga_pkg and the RTL of set_union_with_group_add.
module testbench;

  localparam int unsigned NUM_MEMBERS = 1024;
  localparam logic [suga_pkg::FuncW-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [suga_pkg::MemberW-1:0] MEMBER_LAST = 10'd1023;
  localparam int unsigned AMOUNT_MAX = 1000000;
  localparam int unsigned SETTLE_CYCLES = NUM_MEMBERS + 16;
  localparam int unsigned CYCLE_LIMIT = 4000000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic [suga_pkg::FuncW-1:0] func_i;
  logic [suga_pkg::MemberW-1:0] member_i;
  logic [suga_pkg::MemberW-1:0] partner_i;
  logic [suga_pkg::AmountW-1:0] amount_i;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [suga_pkg::ValueW-1:0] value_o;

  logic [suga_pkg::MemberW-1:0] label_of [NUM_MEMBERS];
  logic [suga_pkg::ValueW-1:0] total_of [NUM_MEMBERS];
  logic [suga_pkg::ValueW-1:0] values_due [$];
  logic [suga_pkg::ValueW-1:0] oldest_value;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_len = 0;
  int hold_left = 0;
  logic hold_go = 1'b0;
  logic hold_seen = 1'b0;
  int unsigned cycle_count = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int fail_count = 0;

  set_union_with_group_add #(
    .NUM_MEMBERS(NUM_MEMBERS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .member_i   (member_i),
    .partner_i  (partner_i),
    .amount_i   (amount_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .value_o    (value_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= hold_len;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    out_stall_i <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
  end

  always @(negedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (values_due.size() == 0) begin
        $display("%0t: value %0d arrived with no get outstanding", $time, value_o);
        fail_count++;
      end else begin
        oldest_value = values_due.pop_front();
        results_checked++;
        if (value_o !== oldest_value) begin
          $display("%0t: value mismatch, expected %0d, actual %0d", $time, oldest_value,
                   value_o);
          fail_count++;
        end
      end
    end
  end

  function automatic void apply_group_op(input logic [suga_pkg::FuncW-1:0] func,
                                         input logic [suga_pkg::MemberW-1:0] member,
                                         input logic [suga_pkg::MemberW-1:0] partner,
                                         input logic [suga_pkg::AmountW-1:0] amount);
    logic [suga_pkg::MemberW-1:0] keep;
    logic [suga_pkg::MemberW-1:0] gone;
    logic [suga_pkg::ValueW:0] sum;
    logic [suga_pkg::ValueW-1:0] due;
    case (func)
      suga_pkg::FUNC_ADD: begin
        if (member < NUM_MEMBERS) begin
          keep = label_of[member];
          for (int i = 0; i < NUM_MEMBERS; i++) begin
            if (label_of[i] == keep) begin
              sum = {1'b0, total_of[i]} + amount;
              total_of[i] = sum[suga_pkg::ValueW] ? '1 : sum[suga_pkg::ValueW-1:0];
            end
          end
        end
      end
      suga_pkg::FUNC_JOIN: begin
        if (member < NUM_MEMBERS && partner < NUM_MEMBERS) begin
          keep = label_of[member];
          gone = label_of[partner];
          if (keep != gone) begin
            for (int i = 0; i < NUM_MEMBERS; i++) begin
              if (label_of[i] == gone) label_of[i] = keep;
            end
          end
        end
      end
      suga_pkg::FUNC_GET: begin
        due = (member < NUM_MEMBERS) ? total_of[member] : '0;
        values_due = {values_due, due};
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_request(input logic [suga_pkg::FuncW-1:0] func,
                              input logic [suga_pkg::MemberW-1:0] member,
                              input logic [suga_pkg::MemberW-1:0] partner,
                              input logic [suga_pkg::AmountW-1:0] amount);
    in_valid_i <= 1'b1;
    func_i <= func;
    member_i <= member;
    partner_i <= partner;
    amount_i <= amount;
    @(negedge clk_i);
    while (in_stall_o !== 1'b0) @(negedge clk_i);
    @(posedge clk_i);
    apply_group_op(func, member, partner, amount);
    requests_sent++;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_all_results(input int unsigned settle);
    in_valid_i <= 1'b0;
    while (values_due.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  function automatic logic [suga_pkg::MemberW-1:0] pick_member(input int base);
    int r;
    r = $urandom_range(99);
    if (r < 70) return suga_pkg::MemberW'(base + $urandom_range(31));
    if (r < 80) return $urandom_range(1) ? MEMBER_LAST : '0;
    return suga_pkg::MemberW'($urandom_range(NUM_MEMBERS - 1));
  endfunction

  task automatic test_reset_values();
    send_request(suga_pkg::FUNC_GET, '0, '0, '0);
    send_request(suga_pkg::FUNC_GET, MEMBER_LAST, MEMBER_LAST, '0);
    send_request(suga_pkg::FUNC_GET, 10'd341, 10'd682, 20'd699050);
    send_request(suga_pkg::FUNC_GET, 10'd682, 10'd341, 20'd349525);
  endtask

  task automatic test_add_extremes();
    send_request(suga_pkg::FUNC_ADD, '0, MEMBER_LAST, suga_pkg::AmountW'(AMOUNT_MAX));
    send_request(suga_pkg::FUNC_ADD, MEMBER_LAST, '0, '0);
    send_request(suga_pkg::FUNC_ADD, MEMBER_LAST, '0, 20'd1);
    send_request(suga_pkg::FUNC_GET, '0, '0, '0);
    send_request(suga_pkg::FUNC_GET, MEMBER_LAST, '0, '0);
    send_request(suga_pkg::FUNC_GET, 10'd1, '0, '0);
  endtask

  task automatic test_join_and_add();
    send_request(suga_pkg::FUNC_JOIN, 10'd5, 10'd6, '0);
    send_request(suga_pkg::FUNC_JOIN, 10'd7, 10'd6, '0);
    send_request(suga_pkg::FUNC_ADD, 10'd5, '0, 20'd300);
    send_request(suga_pkg::FUNC_GET, 10'd6, '0, '0);
    send_request(suga_pkg::FUNC_GET, 10'd7, '0, '0);
    send_request(suga_pkg::FUNC_GET, 10'd8, '0, '0);
    send_request(suga_pkg::FUNC_JOIN, MEMBER_LAST, '0, '0);
    send_request(suga_pkg::FUNC_GET, '0, '0, '0);
  endtask

  task automatic test_join_within_group();
    send_request(suga_pkg::FUNC_JOIN, 10'd6, 10'd5, '0);
    send_request(suga_pkg::FUNC_JOIN, 10'd9, 10'd9, '0);
    send_request(suga_pkg::FUNC_ADD, 10'd9, '0, 20'd7);
    send_request(suga_pkg::FUNC_GET, 10'd9, '0, '0);
    send_request(suga_pkg::FUNC_GET, 10'd5, '0, '0);
  endtask

  task automatic test_unused_func();
    send_request(FUNC_UNUSED, MEMBER_LAST, MEMBER_LAST, suga_pkg::AmountW'(AMOUNT_MAX));
    send_request(suga_pkg::FUNC_GET, MEMBER_LAST, '0, '0);
    wait_all_results(SETTLE_CYCLES);
  endtask

  task automatic test_random_traffic(input int count, input int idle, input int stall,
                                     input int base);
    int done;
    int pick;
    logic [suga_pkg::FuncW-1:0] func;
    idle_pct = idle;
    stall_pct = stall;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      if (pick < 30) func = suga_pkg::FUNC_ADD;
      else if (pick < 55) func = suga_pkg::FUNC_JOIN;
      else if (pick < 96) func = suga_pkg::FUNC_GET;
      else func = FUNC_UNUSED;
      send_request(func, pick_member(base), pick_member(base),
                   suga_pkg::AmountW'($urandom_range(AMOUNT_MAX)));
      if (func != FUNC_UNUSED) done++;
    end
    wait_all_results(0);
  endtask

  task automatic test_output_hold();
    idle_pct = 0;
    stall_pct = 0;
    hold_len = 400;
    hold_go = ~hold_go;
    for (int i = 0; i < 12; i++) begin
      send_request(suga_pkg::FUNC_GET, suga_pkg::MemberW'(i * 85), '0, '0);
      if (i == 5) send_request(suga_pkg::FUNC_ADD, suga_pkg::MemberW'(i * 85), '0, 20'd1234);
    end
    wait_all_results(0);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    func_i = suga_pkg::FUNC_ADD;
    member_i = '0;
    partner_i = '0;
    amount_i = '0;
    for (int i = 0; i < NUM_MEMBERS; i++) begin
      label_of[i] = suga_pkg::MemberW'(i);
      total_of[i] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_add_extremes();
    test_join_and_add();
    test_join_within_group();
    test_unused_func();
    test_random_traffic(130, 0, 0, 0);
    test_random_traffic(130, 80, 0, 256);
    test_random_traffic(130, 0, 80, 512);
    test_random_traffic(130, 34, 34, 992);
    test_output_hold();
    wait_all_results(SETTLE_CYCLES);

    $display("Sent %0d requests and checked %0d get values in %0d cycles.", requests_sent,
             results_checked, cycle_count);
    $display("Covered adds, joins, same-group joins, unused func, idle, stall and hold-off.");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
